/* rtl/fsp_pkg.sv */
package fsp_pkg;

	localparam int FIELD_COUNT  = 14;
	localparam int PAYLOAD_BASE = 80;
	localparam int OFFSET_W     = 14;
	localparam int POS_W        = 14;
	localparam int IDX_W        = 4;
	localparam int ENT_W        = $clog2(FIELD_COUNT);
	localparam int REL_W        = ENT_W + 2;
	localparam int TABLE_START  = 4;
	localparam int TABLE_END    = TABLE_START + 4 * FIELD_COUNT;
	localparam int TYPE_LEN     = 4;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_ONE  = 8'h31;

	localparam logic [1:0] PHASE_FIRST = 2'd0;
	localparam logic [1:0] PHASE_DASH  = 2'd2;
	localparam logic [1:0] PHASE_LAST  = 2'd3;

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       msg_last;
	} msg_t;

	typedef struct packed {
		logic [IDX_W-1:0] field_index;
		logic [7:0]       field_byte;
		logic             field_end;
		logic             header_bad;
	} field_t;

	// Character expected at each place of the absent marker "00-1".
	function automatic logic [7:0] absent_char(input logic [1:0] phase);
		logic [7:0] ch;
		case (phase)
			PHASE_DASH: ch = CH_DASH;
			PHASE_LAST: ch = CH_ONE;
			default:    ch = CH_ZERO;
		endcase
		return ch;
	endfunction

endpackage

/* rtl/fsp_front.sv */
module fsp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  fsp_pkg::msg_t msg,
	input  logic          take,
	output fsp_pkg::field_t res,
	output logic          res_valid
);
	import fsp_pkg::*;

	logic [POS_W-1:0]    pos_q;
	logic [OFFSET_W-1:0] acc_q;
	logic                match_q;
	logic                bad_q;
	logic [OFFSET_W-1:0] off_q [FIELD_COUNT];
	logic [OFFSET_W-1:0] nxt_q [FIELD_COUNT];
	logic [FIELD_COUNT-1:0] present_q;
	logic [FIELD_COUNT-1:0] has_next_q;

	logic                in_table;
	logic                in_payload;
	logic [POS_W-1:0]    rel_full;
	logic [REL_W-1:0]    rel;
	logic [ENT_W-1:0]    entry;
	logic [1:0]          phase;
	logic                is_digit;
	logic [3:0]          dv;
	logic                run_in;
	logic                now;
	logic                char_err;
	logic [OFFSET_W-1:0] acc_next;
	logic [POS_W-1:0]    p;
	logic [POS_W-1:0]    p_inc;
	logic                hit;
	logic [IDX_W-1:0]    hit_idx;
	logic                hit_end;

	assign in_table   = (pos_q >= POS_W'(TABLE_START)) && (pos_q < POS_W'(TABLE_END));
	assign in_payload = pos_q >= POS_W'(PAYLOAD_BASE);
	assign rel_full   = pos_q - POS_W'(TABLE_START);
	assign rel        = rel_full[REL_W-1:0];
	assign entry      = rel[REL_W-1:2];
	assign phase      = rel[1:0];

	// Offset character decode: one decimal digit or part of the absent marker.
	always_comb begin
		is_digit = (msg.msg_byte >= CH_ZERO) && (msg.msg_byte <= CH_NINE);
		dv       = is_digit ? 4'(msg.msg_byte - CH_ZERO) : 4'd0;
		run_in   = (phase == PHASE_FIRST) ? 1'b1 : match_q;
		now      = run_in && (msg.msg_byte == absent_char(phase));
		if (phase == PHASE_FIRST) begin
			acc_next = OFFSET_W'(dv);
		end else begin
			acc_next = (acc_q << 3) + (acc_q << 1) + OFFSET_W'(dv);
		end
		char_err = !is_digit && !(phase == PHASE_DASH && run_in && msg.msg_byte == CH_DASH);
		if (phase == PHASE_LAST && run_in && msg.msg_byte != CH_ONE) begin
			char_err = 1'b1;
		end
	end

	// Payload lookup: all fields compare in parallel, the lowest index wins.
	assign p     = pos_q - POS_W'(PAYLOAD_BASE);
	assign p_inc = p + POS_W'(1);

	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		hit_end = 1'b0;
		if (p < POS_W'(TYPE_LEN)) begin
			hit     = 1'b1;
			hit_end = (p == POS_W'(TYPE_LEN - 1)) || msg.msg_last;
		end else begin
			for (int k = FIELD_COUNT - 1; k >= 0; k--) begin
				if (present_q[k] && (off_q[k] <= p) &&
				    (!has_next_q[k] || (p < nxt_q[k]))) begin
					hit     = 1'b1;
					hit_idx = IDX_W'(k + 1);
					hit_end = msg.msg_last || (has_next_q[k] && (p_inc == nxt_q[k]));
				end
			end
		end
	end

	assign res_valid       = take && in_payload && hit;
	assign res.field_index = hit_idx;
	assign res.field_byte  = msg.msg_byte;
	assign res.field_end   = hit_end;
	assign res.header_bad  = bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			acc_q      <= '0;
			match_q    <= 1'b1;
			bad_q      <= 1'b0;
			has_next_q <= '0;
		end else if (take) begin
			if (msg.msg_last) begin
				pos_q      <= '0;
				acc_q      <= '0;
				match_q    <= 1'b1;
				bad_q      <= 1'b0;
				has_next_q <= '0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + POS_W'(1);
				end
				if (in_table) begin
					if (char_err) begin
						bad_q <= 1'b1;
					end
					if (phase == PHASE_LAST) begin
						acc_q   <= '0;
						match_q <= 1'b1;
						// A present entry becomes the end of every earlier field still open.
						if (!now) begin
							for (int k = 0; k < FIELD_COUNT; k++) begin
								if (ENT_W'(k) < entry && !has_next_q[k]) begin
									has_next_q[k] <= 1'b1;
								end
							end
						end
					end else begin
						acc_q   <= acc_next;
						match_q <= now;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !msg.msg_last && in_table && phase == PHASE_LAST) begin
			off_q[entry]     <= acc_next;
			present_q[entry] <= !now;
			if (!now) begin
				for (int k = 0; k < FIELD_COUNT; k++) begin
					if (ENT_W'(k) < entry && !has_next_q[k]) begin
						nxt_q[k] <= acc_next;
					end
				end
			end
		end
	end

endmodule

/* rtl/fsp_queue.sv */
module fsp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  fsp_pkg::field_t wr_data,
	input  logic            rd_en,
	output fsp_pkg::field_t rd_data,
	output logic            full,
	output logic            empty
);
	import fsp_pkg::*;

	field_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_wr;
	logic                do_rd;

	assign full    = count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (QUEUE_AW + 1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (QUEUE_AW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* rtl/fsp_back.sv */
module fsp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  fsp_pkg::field_t q_data,
	input  logic            q_empty,
	output logic            q_rd,
	output fsp_pkg::field_t field,
	output logic            empty,
	input  logic            pop
);
	import fsp_pkg::*;

	field_t out_q;
	logic   valid_q;

	// Refill the output register whenever it is free or its request leaves this cycle.
	assign q_rd  = !q_empty && (!valid_q || pop);
	assign field = out_q;
	assign empty = !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_rd) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			out_q <= q_data;
		end
	end

endmodule

/* rtl/offset_table_field_splitter_top.sv */
// Splits a message, taken one byte per push, into tagged payload bytes. Header bytes 4 to 59
// carry fourteen 4-character decimal offsets ("00-1" marks an absent field); payload starts at
// byte 80, its first four bytes are the type (field 0), and each present field runs from its
// offset to the next present offset or the end of the message. Header bytes give no result,
// nor do payload bytes that no field covers. The block takes one byte per clock while full is low: the offset
// compare and priority pick happen in the cycle a byte is accepted, the result goes into a
// four-entry queue and reaches the result ports through the output register.
// full rises only when that queue and the output register are both occupied.
module offset_table_field_splitter_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  fsp_pkg::msg_t   msg,
	output logic            empty,
	input  logic            pop,
	output fsp_pkg::field_t field
);
	import fsp_pkg::*;

	field_t res;
	logic   res_valid;
	logic   take;
	field_t q_data;
	logic   q_empty;
	logic   q_rd;

	assign take = push && !full;

	fsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg       (msg),
		.take      (take),
		.res       (res),
		.res_valid (res_valid)
	);

	fsp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res),
		.rd_en   (q_rd),
		.rd_data (q_data),
		.full    (full),
		.empty   (q_empty)
	);

	fsp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (q_data),
		.q_empty (q_empty),
		.q_rd    (q_rd),
		.field   (field),
		.empty   (empty),
		.pop     (pop)
	);

endmodule

/* rtl/fsp_checker.sv */
module fsp_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            full,
	input logic            empty,
	input logic            pop,
	input fsp_pkg::field_t field
);
	import fsp_pkg::*;

	// Tags beyond the table can never be produced.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (field.field_index <= IDX_W'(FIELD_COUNT)))
		else $error("field tag out of range");

	// Nothing can be waiting on the first edge after reset is released.
	assert property (@(posedge clk) $rose(arst_n) |-> empty)
		else $error("result present right after reset");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("waiting request dropped");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(field))
		else $error("waiting request changed");

	// A full queue always sits behind an occupied output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("input stalled while no result is offered");

endmodule

bind offset_table_field_splitter_top fsp_checker u_fsp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.field  (field)
);
